[sv/kgaf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgaf_pkg
// shared widths, register indexes, state encodings and record types
// ----------------------------------------------------------------------------
package kgaf_pkg;

	localparam int MAX_GROUP = 32;
	localparam int IDX_W     = $clog2(MAX_GROUP);
	localparam int CNT_W     = $clog2(MAX_GROUP + 1);
	localparam int READ_W    = 31;
	localparam int ORD_W     = 24;
	localparam int MC_W      = 25;
	localparam int COV_W     = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_COV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COV = 2'd1;

	localparam logic [COV_W-1:0] MIN_COV_RST = 6'd2;
	localparam logic [COV_W-1:0] MAX_COV_RST = 6'd32;

	typedef enum logic {
		COLL_TAKE,
		COLL_SETTLE
	} coll_state_t;

	typedef enum logic [1:0] {
		EMIT_IDLE,
		EMIT_FWD,
		EMIT_RC
	} emit_state_t;

	// one stored occurrence: count field holds marker_count - 1
	typedef struct packed {
		logic [READ_W-1:0] read_id;
		logic              strand;
		logic [ORD_W-1:0]  ordinal;
		logic [ORD_W-1:0]  count;
	} member_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		member_t          data;
	} mem_wr_t;

	typedef struct packed {
		logic             go;
		logic [CNT_W-1:0] count;
	} run_start_t;

	typedef struct packed {
		logic copy_kind;
		logic anchor_end;
		logic run_last;
	} res_tag_t;

	typedef struct packed {
		logic [READ_W-1:0] read_id;
		logic              strand;
		logic [ORD_W-1:0]  ordinal;
		logic              copy_kind;
		logic              anchor_end;
		logic              run_last;
	} result_t;

endpackage
`default_nettype wire

[sv/kgaf_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgaf channel interfaces
// occurrence input, anchor output and register write channels
// ----------------------------------------------------------------------------
interface kgaf_occ_if;
	logic                        valid;
	logic                        ready;
	logic [kgaf_pkg::READ_W-1:0] read_id;
	logic                        strand;
	logic [kgaf_pkg::ORD_W-1:0]  ordinal;
	logic [kgaf_pkg::MC_W-1:0]   marker_count;
	logic                        group_last;

	modport source (output valid, read_id, strand, ordinal, marker_count, group_last,
		input ready);
	modport sink (input valid, read_id, strand, ordinal, marker_count, group_last,
		output ready);
endinterface

interface kgaf_anchor_if;
	logic                        valid;
	logic                        ready;
	logic [kgaf_pkg::READ_W-1:0] out_read_id;
	logic                        out_strand;
	logic [kgaf_pkg::ORD_W-1:0]  out_ordinal;
	logic                        copy_kind;
	logic                        anchor_end;
	logic                        run_last;

	modport source (output valid, out_read_id, out_strand, out_ordinal, copy_kind,
		anchor_end, run_last, input ready);
	modport sink (input valid, out_read_id, out_strand, out_ordinal, copy_kind,
		anchor_end, run_last, output ready);
endinterface

interface kgaf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [kgaf_pkg::CFG_IDX_W-1:0] index;
	logic [kgaf_pkg::COV_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/kmer_group_anchor_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmer_group_anchor_filter
// filters one k-mer group of marker occurrences into forward and
// reverse-complement anchors
//
// occ_in takes one occurrence per beat, group_last on the final one; cfg
// writes min_coverage (index 0) and max_coverage (index 1), always ready.
// anchor_out gives the usable members in order, then again mirrored, with
// anchor_end on each anchor's final member and run_last on the group's end.
// after the final occurrence come the settle state, the emit start, the
// store's read register and the output register before the first result;
// then one result per cycle follows from the store's single read port
// unless the receiver stalls, 2u results for u usable members. occ_in is
// held off while the store is being walked and resumes once the last read
// is issued, while results may still be draining. a stalled receiver holds
// the output register and a skid stage, and the store walk pauses until
// one of them frees. reset empties the group, clears the output stage and
// loads min_coverage 2 and max_coverage 32; the store needs no clearing.
// ----------------------------------------------------------------------------
module kmer_group_anchor_filter (
	input  wire             clk,
	input  wire             arst_n,
	kgaf_occ_if.sink        occ_in,
	kgaf_anchor_if.source   anchor_out,
	kgaf_cfg_if.sink        cfg
);

	kgaf_pkg::mem_wr_t           wr;
	kgaf_pkg::run_start_t        start;
	kgaf_pkg::member_t           rdata;
	logic [kgaf_pkg::IDX_W-1:0]  raddr;
	logic                        emit_busy;

	kgaf_store u_store (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	kgaf_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.occ_in    (occ_in),
		.cfg       (cfg),
		.emit_busy (emit_busy),
		.wr        (wr),
		.start     (start)
	);

	kgaf_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.rdata      (rdata),
		.raddr      (raddr),
		.busy       (emit_busy),
		.anchor_out (anchor_out)
	);

endmodule
`default_nettype wire

[sv/kgaf_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgaf_store
// usable member memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module kgaf_store (
	input  wire                           clk,
	input  kgaf_pkg::mem_wr_t             wr,
	input  wire [kgaf_pkg::IDX_W-1:0]     raddr,
	output kgaf_pkg::member_t             rdata
);

	kgaf_pkg::member_t mem_q [kgaf_pkg::MAX_GROUP];
	kgaf_pkg::member_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[sv/kgaf_collect.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgaf_collect
// takes occurrences, settles usability against neighbours, writes usable
// members to the store and decides at group end whether to emit
// ----------------------------------------------------------------------------
module kgaf_collect (
	input  wire                    clk,
	input  wire                    arst_n,
	kgaf_occ_if.sink               occ_in,
	kgaf_cfg_if.sink               cfg,
	input  wire                    emit_busy,
	output kgaf_pkg::mem_wr_t      wr,
	output kgaf_pkg::run_start_t   start
);

	kgaf_pkg::coll_state_t         state_q, state_d;
	logic [kgaf_pkg::COV_W-1:0]    min_cov_q, max_cov_q;
	kgaf_pkg::member_t             held_q;
	logic                          held_valid_q;
	logic [kgaf_pkg::READ_W-1:0]   prev_read_q;
	logic [kgaf_pkg::COV_W-1:0]    group_size_q;
	logic [kgaf_pkg::CNT_W-1:0]    usable_cnt_q;

	logic                          take;
	logic                          settle;
	logic                          has_prev;
	logic                          usable;
	logic                          wr_en;
	logic [kgaf_pkg::CNT_W-1:0]    usable_next;
	logic                          pass;
	kgaf_pkg::member_t             new_item;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cov_q <= kgaf_pkg::MIN_COV_RST;
			max_cov_q <= kgaf_pkg::MAX_COV_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				kgaf_pkg::CFG_MIN_COV: min_cov_q <= cfg.data;
				kgaf_pkg::CFG_MAX_COV: max_cov_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kgaf_pkg::COLL_TAKE: begin
				if (take && occ_in.group_last) begin
					state_d = kgaf_pkg::COLL_SETTLE;
				end
			end
			kgaf_pkg::COLL_SETTLE: state_d = kgaf_pkg::COLL_TAKE;
			default: state_d = kgaf_pkg::COLL_TAKE;
		endcase
	end

	// outputs
	always_comb begin
		occ_in.ready = 1'b0;
		settle       = 1'b0;
		case (state_q)
			kgaf_pkg::COLL_TAKE:   occ_in.ready = !emit_busy;
			kgaf_pkg::COLL_SETTLE: settle = 1'b1;
			default: ;
		endcase
	end

	assign take = occ_in.valid && occ_in.ready;

	assign new_item.read_id = occ_in.read_id;
	assign new_item.strand  = occ_in.strand;
	assign new_item.ordinal = occ_in.ordinal;
	assign new_item.count   = occ_in.marker_count[kgaf_pkg::ORD_W-1:0] - 24'd1;

	assign has_prev = (group_size_q > 6'd1) && (prev_read_q == held_q.read_id);
	assign usable   = !has_prev && (settle || (occ_in.read_id != held_q.read_id));
	assign wr_en    = (settle || (take && held_valid_q)) && usable &&
		(usable_cnt_q < kgaf_pkg::CNT_W'(kgaf_pkg::MAX_GROUP));
	assign usable_next = usable_cnt_q + kgaf_pkg::CNT_W'(wr_en);

	assign wr.en   = wr_en;
	assign wr.addr = usable_cnt_q[kgaf_pkg::IDX_W-1:0];
	assign wr.data = held_q;

	assign pass = !(group_size_q > max_cov_q) &&
		!(group_size_q > kgaf_pkg::COV_W'(kgaf_pkg::MAX_GROUP)) &&
		!(kgaf_pkg::COV_W'(usable_next) < min_cov_q) &&
		(usable_next != '0);

	assign start.go    = settle && pass;
	assign start.count = usable_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kgaf_pkg::COLL_TAKE;
			held_valid_q <= 1'b0;
			prev_read_q  <= '0;
			group_size_q <= '0;
			usable_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (settle) begin
				held_valid_q <= 1'b0;
				prev_read_q  <= '0;
				group_size_q <= '0;
				usable_cnt_q <= '0;
			end else if (take) begin
				held_valid_q <= 1'b1;
				usable_cnt_q <= usable_next;
				if (held_valid_q) begin
					prev_read_q <= held_q.read_id;
				end
				if (group_size_q != '1) begin
					group_size_q <= group_size_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			held_q <= new_item;
		end
	end

endmodule
`default_nettype wire

[sv/kgaf_emit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgaf_emit
// walks the store twice (forward, then reverse complement), one read per cycle
// unless stalled, with an output register and skid stage behind the read port
// ----------------------------------------------------------------------------
module kgaf_emit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  kgaf_pkg::run_start_t         start,
	input  kgaf_pkg::member_t            rdata,
	output logic [kgaf_pkg::IDX_W-1:0]   raddr,
	output logic                         busy,
	kgaf_anchor_if.source                anchor_out
);

	kgaf_pkg::emit_state_t        state_q, state_d;
	logic [kgaf_pkg::IDX_W-1:0]   k_q;
	logic [kgaf_pkg::CNT_W-1:0]   u_q;
	logic                         rd_v_s1;
	kgaf_pkg::res_tag_t           tag_s1;
	logic                         out_v_q, skid_v_q;
	kgaf_pkg::result_t            out_q, skid_q;

	logic                         copy;
	logic                         at_end;
	logic                         pop;
	logic                         out_free;
	logic [1:0]                   occ;
	logic                         issue;
	kgaf_pkg::res_tag_t           tag_d;
	kgaf_pkg::result_t            res;

	assign pop      = out_v_q && anchor_out.ready;
	assign out_free = !out_v_q || pop;
	assign occ      = {1'b0, rd_v_s1} + {1'b0, out_v_q} + {1'b0, skid_v_q} - {1'b0, pop};
	assign at_end   = ({1'b0, k_q} == (u_q - kgaf_pkg::CNT_W'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kgaf_pkg::EMIT_IDLE: begin
				if (start.go) begin
					state_d = kgaf_pkg::EMIT_FWD;
				end
			end
			kgaf_pkg::EMIT_FWD: begin
				if (issue && at_end) begin
					state_d = kgaf_pkg::EMIT_RC;
				end
			end
			kgaf_pkg::EMIT_RC: begin
				if (issue && at_end) begin
					state_d = kgaf_pkg::EMIT_IDLE;
				end
			end
			default: state_d = kgaf_pkg::EMIT_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		copy = 1'b0;
		case (state_q)
			kgaf_pkg::EMIT_IDLE: busy = 1'b0;
			kgaf_pkg::EMIT_FWD:  copy = 1'b0;
			kgaf_pkg::EMIT_RC:   copy = 1'b1;
			default:             busy = 1'b0;
		endcase
	end

	assign issue = busy && (occ < 2'd2);
	assign raddr = k_q;

	assign tag_d.copy_kind  = copy;
	assign tag_d.anchor_end = at_end;
	assign tag_d.run_last   = at_end && copy;

	// reverse-complement form mirrors the ordinal on the oriented read
	assign res.read_id    = rdata.read_id;
	assign res.strand     = rdata.strand ^ tag_s1.copy_kind;
	assign res.ordinal    = tag_s1.copy_kind ? (rdata.count - rdata.ordinal) : rdata.ordinal;
	assign res.copy_kind  = tag_s1.copy_kind;
	assign res.anchor_end = tag_s1.anchor_end;
	assign res.run_last   = tag_s1.run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kgaf_pkg::EMIT_IDLE;
			k_q      <= '0;
			u_q      <= '0;
			rd_v_s1  <= 1'b0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (start.go && !busy) begin
				k_q <= '0;
				u_q <= start.count;
			end else if (issue) begin
				k_q <= at_end ? '0 : k_q + kgaf_pkg::IDX_W'(1);
			end
			if (out_free) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= rd_v_s1;
				end else begin
					out_v_q <= rd_v_s1;
				end
			end else if (rd_v_s1) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tag_s1 <= tag_d;
		end
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (rd_v_s1) begin
					skid_q <= res;
				end
			end else if (rd_v_s1) begin
				out_q <= res;
			end
		end else if (rd_v_s1) begin
			skid_q <= res;
		end
	end

	assign anchor_out.valid       = out_v_q;
	assign anchor_out.out_read_id = out_q.read_id;
	assign anchor_out.out_strand  = out_q.strand;
	assign anchor_out.out_ordinal = out_q.ordinal;
	assign anchor_out.copy_kind   = out_q.copy_kind;
	assign anchor_out.anchor_end  = out_q.anchor_end;
	assign anchor_out.run_last    = out_q.run_last;

endmodule
`default_nettype wire
